// ===== design/act_pkg.sv =====
// Shared types, register indexes and reset values for the adaptive concurrency throttle.
// No dependencies; imported by every module of the block.
package act_pkg;

  // Field widths
  localparam int LIM_W     = 11;
  localparam int RATE_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Default for the active count ceiling
  localparam int MAX_ACTIVE_DEF = 1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIMIT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH_STEP    = 2'd3;

  // Register reset values
  localparam logic [LIM_W-1:0]  INIT_LIMIT_RST     = 11'd100;
  localparam logic [LIM_W-1:0]  FALLBACK_LIMIT_RST = 11'd10;
  localparam logic [LIM_W-1:0]  MAX_LIMIT_RST      = 11'd1000;
  localparam logic [RATE_W-1:0] GROWTH_STEP_RST    = 16'd100;

  // Event kinds
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic req_type;
    logic success;
  } in_item_t;

  typedef struct packed {
    logic             high_load;
    logic [LIM_W-1:0] current_limit;
    logic [LIM_W-1:0] active_count;
  } out_item_t;

  // Settings that steer the limit adaptation
  typedef struct packed {
    logic [LIM_W-1:0]  fallback_limit;
    logic [LIM_W-1:0]  max_limit;
    logic [RATE_W-1:0] growth_step;
  } act_cfg_t;

  // Load of the current limit on an initial-limit write
  typedef struct packed {
    logic             load;
    logic [LIM_W-1:0] value;
  } limit_load_t;

endpackage

// ===== design/act_cfg_regs.sv =====
// Configuration registers of the throttle: fallback limit, maximum limit, growth step.
// Depends on act_pkg; also signals an initial-limit write so the core reloads its limit.
module act_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [act_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [act_pkg::CFG_W-1:0]      cfg_wdata,
  output act_pkg::act_cfg_t              cfg,
  output act_pkg::limit_load_t           lim_load
);
  import act_pkg::*;

  logic [LIM_W-1:0]  restart_r, restart_nxt;
  logic [LIM_W-1:0]  max_r, max_nxt;
  logic [RATE_W-1:0] rate_r, rate_nxt;

  // Register write decode
  always_comb begin
    restart_nxt = restart_r;
    max_nxt     = max_r;
    rate_nxt    = rate_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_FALLBACK_LIMIT: restart_nxt = cfg_wdata[LIM_W-1:0];
        CFG_MAX_LIMIT:      max_nxt     = cfg_wdata[LIM_W-1:0];
        CFG_GROWTH_STEP:    rate_nxt    = cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      restart_r <= FALLBACK_LIMIT_RST;
      max_r     <= MAX_LIMIT_RST;
      rate_r    <= GROWTH_STEP_RST;
    end else begin
      restart_r <= restart_nxt;
      max_r     <= max_nxt;
      rate_r    <= rate_nxt;
    end
  end

  // The initial limit is not kept: a write only reloads the current limit
  assign lim_load.load  = cfg_we && (cfg_idx == CFG_INIT_LIMIT);
  assign lim_load.value = cfg_wdata[LIM_W-1:0];

  assign cfg.fallback_limit = restart_r;
  assign cfg.max_limit      = max_r;
  assign cfg.growth_step    = rate_r;

endmodule

// ===== design/act_core.sv =====
// State of the throttle (active count, limit, success counter, load flag) and its update.
// Depends on act_pkg; the result for an item is the state after that item.
module act_core #(
  parameter int MAX_ACTIVE = act_pkg::MAX_ACTIVE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 upd,
  input  act_pkg::in_item_t    item,
  input  act_pkg::act_cfg_t    cfg,
  input  act_pkg::limit_load_t lim_load,
  output act_pkg::out_item_t   result
);
  import act_pkg::*;

  localparam int CNT_W = $clog2(MAX_ACTIVE + 1);
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ACTIVE);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LIM_W-1:0]  lim_r, lim_nxt;
  logic [RATE_W-1:0] succ_r, succ_nxt;
  logic              flag_r, flag_nxt;

  logic [RATE_W:0]   succ_inc;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  lim_ext;
  logic              below_lim;

  assign lim_ext  = CMP_W'(lim_r);
  assign cnt_ext  = CMP_W'(cnt_nxt);
  assign below_lim = cnt_ext < lim_ext;
  assign succ_inc = {1'b0, succ_r} + {{RATE_W{1'b0}}, 1'b1};

  // Next state for one item
  always_comb begin
    cnt_nxt  = cnt_r;
    lim_nxt  = lim_r;
    succ_nxt = succ_r;
    flag_nxt = flag_r;
    if (item.req_type == REQ_START) begin
      if (cnt_r != CNT_MAX) cnt_nxt = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
      if (below_lim) begin
        flag_nxt = 1'b0;
      end else begin
        flag_nxt = 1'b1;
        succ_nxt = '0;
        if (lim_r > cfg.fallback_limit) lim_nxt = cfg.fallback_limit;
      end
    end else begin
      if (cnt_r != '0) cnt_nxt = cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
      if (below_lim) flag_nxt = 1'b0;
      if (item.success) begin
        if (succ_inc >= {1'b0, cfg.growth_step}) begin
          succ_nxt = '0;
          if (lim_r < cfg.max_limit) lim_nxt = lim_r + {{(LIM_W-1){1'b0}}, 1'b1};
        end else begin
          succ_nxt = succ_inc[RATE_W-1:0];
        end
      end
    end
  end

  // State registers; an initial-limit write reloads the limit while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lim_r  <= INIT_LIMIT_RST;
      succ_r <= '0;
      flag_r <= 1'b0;
    end else if (upd) begin
      cnt_r  <= cnt_nxt;
      lim_r  <= lim_nxt;
      succ_r <= succ_nxt;
      flag_r <= flag_nxt;
    end else if (lim_load.load) begin
      lim_r <= lim_load.value;
    end
  end

  assign result.high_load     = flag_nxt;
  assign result.current_limit = lim_nxt;
  assign result.active_count  = cnt_ext[LIM_W-1:0];

  // Count never passes its ceiling
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX) else $error("active count above ceiling");

  // A start under high load clears the success counter
  a_succ_clr: assert property (@(posedge clk) disable iff (!rst_n)
    upd && (item.req_type == REQ_START) && flag_nxt |=> succ_r == '0)
    else $error("success counter not cleared on high load");

  // Count only moves on an item
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(cnt_r)) else $error("active count moved without item");

endmodule

// ===== design/adaptive_concurrency_throttle.sv =====
// Adaptive concurrency throttle: input register, state update, result register.
// Throughput one item per cycle while the result register is not stalled by out_ready.
// The state update is a single pass of compares and increments on the stored state.
// Reset (rst_n low, synchronous): pipeline empty, count and success counter zero,
// limit 100, registers at their reset values.
// Depends on act_pkg, act_cfg_regs and act_core.
module adaptive_concurrency_throttle #(
  parameter int MAX_ACTIVE = act_pkg::MAX_ACTIVE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  act_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output act_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [act_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [act_pkg::CFG_W-1:0]     cfg_wdata
);
  import act_pkg::*;

  logic        in_v_r, in_v_nxt;
  in_item_t    in_d_r;
  logic        out_v_r, out_v_nxt;
  out_item_t   out_d_r;
  logic        adv;
  act_cfg_t    cfg;
  limit_load_t lim_load;
  out_item_t   result;

  act_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .lim_load  (lim_load)
  );

  act_core #(.MAX_ACTIVE(MAX_ACTIVE)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (adv),
    .item     (in_d_r),
    .cfg      (cfg),
    .lim_load (lim_load),
    .result   (result)
  );

  // Item moves from input register to result register when the latter is empty or being read
  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  always_comb begin
    in_v_nxt = in_v_r;
    if (adv) in_v_nxt = 1'b0;
    if (in_valid && in_ready) in_v_nxt = 1'b1;
    out_v_nxt = out_v_r;
    if (out_v_r && out_ready) out_v_nxt = 1'b0;
    if (adv) out_v_nxt = 1'b1;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_d_r <= in_data;
    if (adv) out_d_r <= result;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // An empty input stage always takes an item
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_ready) else $error("input stage empty but not ready");

  // An item that advances shows up as a result
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r) else $error("advanced item lost");

  // A held item stays in the input stage
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r) else $error("input item dropped");

endmodule

// ===== sim/adaptive_concurrency_throttle_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for adaptive_concurrency_throttle: predicts every result item
// from its own copy of the state and registers, and compares field by field.
// Depends on act_pkg and the throttle RTL.
module adaptive_concurrency_throttle_tb;
  import act_pkg::*;

  localparam int THROTTLE_MAX_ACTIVE = MAX_ACTIVE_DEF;
  localparam int CYCLE_LIMIT         = 600000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  adaptive_concurrency_throttle #(
    .MAX_ACTIVE(THROTTLE_MAX_ACTIVE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted throttle state and register copies
  logic [LIM_W-1:0]  busy_cnt  = '0;
  logic [LIM_W-1:0]  lim_cur   = INIT_LIMIT_RST;
  logic [RATE_W-1:0] ok_run    = '0;
  logic              overload  = 1'b0;
  logic [LIM_W-1:0]  r_restart = FALLBACK_LIMIT_RST;
  logic [LIM_W-1:0]  r_ceiling = MAX_LIMIT_RST;
  logic [RATE_W-1:0] r_rate    = GROWTH_STEP_RST;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int cycle_count     = 0;
  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int phases_run      = 0;
  int peak_busy       = 0;
  int overload_seen   = 0;
  bit send_quiet      = 1'b0;
  bit recv_quiet      = 1'b0;
  int send_gap        = 0;
  int recv_gap        = 0;

  // Advance the predicted state by one item and queue the result it gives
  task automatic throttle_step(input in_item_t item);
    logic [RATE_W:0] next_ok;
    out_item_t       res;
    if (item.req_type == REQ_START) begin
      if (busy_cnt < THROTTLE_MAX_ACTIVE) busy_cnt = busy_cnt + 1'b1;
      if (busy_cnt < lim_cur) begin
        overload = 1'b0;
      end else begin
        overload = 1'b1;
        ok_run   = '0;
        if (lim_cur > r_restart) lim_cur = r_restart;
      end
    end else begin
      if (busy_cnt > 0) busy_cnt = busy_cnt - 1'b1;
      if (busy_cnt < lim_cur) overload = 1'b0;
      if (item.success) begin
        next_ok = {1'b0, ok_run} + 1'b1;
        if (next_ok >= {1'b0, r_rate}) begin
          ok_run = '0;
          if (lim_cur < r_ceiling) lim_cur = lim_cur + 1'b1;
        end else begin
          ok_run = next_ok[RATE_W-1:0];
        end
      end
    end
    res.high_load     = overload;
    res.current_limit = lim_cur;
    res.active_count  = busy_cnt;
    expected_results = {expected_results, res};
    if (int'(busy_cnt) > peak_busy) peak_busy = int'(busy_cnt);
    if (overload) overload_seen++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result item with nothing expected");
    end else begin
      want = expected_results.pop_front();
      if (got.high_load !== want.high_load)
        report_mismatch($sformatf("high_load %0b, expected %0b",
                                  got.high_load, want.high_load));
      if (got.current_limit !== want.current_limit)
        report_mismatch($sformatf("current_limit %0d, expected %0d",
                                  got.current_limit, want.current_limit));
      if (got.active_count !== want.active_count)
        report_mismatch($sformatf("active_count %0d, expected %0d",
                                  got.active_count, want.active_count));
    end
    results_checked++;
  endtask

  // Input driver: one item per handshake, random gap after each
  always @(posedge clk) begin : driver
    int gap_now;
    gap_now = send_gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_now  = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        throttle_step(in_data);
        items_sent++;
        if ($urandom_range(0, 39) == 0) send_quiet = ~send_quiet;
        gap_now = send_quiet ? 0 : $urandom_range(0, 19);
      end
      if (gap_now == 0 && pending_items.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
        if (gap_now != 0) gap_now--;
      end
    end
    send_gap = gap_now;
  end

  // Result monitor: checks each accepted result, stalls at random after it
  always @(posedge clk) begin : monitor
    int stall_now;
    stall_now = recv_gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_now = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        if ($urandom_range(0, 39) == 0) recv_quiet = ~recv_quiet;
        stall_now = recv_quiet ? 0 : $urandom_range(0, 19);
      end
      if (stall_now != 0) begin
        out_ready <= 1'b0;
        stall_now--;
      end else begin
        out_ready <= 1'b1;
      end
    end
    recv_gap = stall_now;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_item(input logic kind, input logic ok);
    in_item_t item;
    item.req_type = kind;
    item.success  = ok;
    pending_items = {pending_items, item};
  endtask

  task automatic add_random(input int count, input int start_pct);
    for (int i = 0; i < count; i++)
      add_item(($urandom_range(0, 99) < start_pct) ? REQ_START : REQ_FINISH,
               1'($urandom_range(0, 1)));
  endtask

  // Wait until every queued item has gone in and every result has come back
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_INIT_LIMIT: lim_cur = value[LIM_W-1:0];
      CFG_FALLBACK_LIMIT: r_restart = value[LIM_W-1:0];
      CFG_MAX_LIMIT: r_ceiling = value[LIM_W-1:0];
      CFG_GROWTH_STEP: r_rate = value[RATE_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] start_v, input logic [CFG_W-1:0] restart_v,
                           input logic [CFG_W-1:0] max_v, input logic [CFG_W-1:0] rate_v);
    write_reg(CFG_INIT_LIMIT, start_v);
    write_reg(CFG_FALLBACK_LIMIT, restart_v);
    write_reg(CFG_MAX_LIMIT, max_v);
    write_reg(CFG_GROWTH_STEP, rate_v);
    close_writes();
    phases_run++;
  endtask

  // Limit values: edges, over-range words and small values near the count
  function automatic logic [CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 16'd1024;
      2: return 16'hFFFF;
      3, 4: return 16'($urandom_range(0, 40));
      5: return 16'($urandom);
      default: return 16'($urandom_range(0, 1024));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_rate();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Reset settings: finishes with nothing active, starts carrying a success bit
    add_item(REQ_FINISH, 1'b0);
    add_item(REQ_FINISH, 1'b1);
    add_item(REQ_START, 1'b0);
    add_item(REQ_START, 1'b1);
    add_item(REQ_START, 1'b0);
    add_item(REQ_FINISH, 1'b1);
    add_item(REQ_FINISH, 1'b0);
    drain();

    // Zero rate: every success steps the limit, up to the ceiling; then overload
    configure(16'd5, 16'd2, 16'd7, 16'd0);
    repeat (3) add_item(REQ_FINISH, 1'b1);
    repeat (8) add_item(REQ_START, 1'b0);
    add_item(REQ_FINISH, 1'b0);
    drain();

    // Limit above the ceiling, then rate lowered beneath the running count
    configure(16'hFFFF, 16'd0, 16'd0, 16'd5);
    repeat (3) add_item(REQ_FINISH, 1'b1);
    drain();
    write_reg(CFG_GROWTH_STEP, 16'd2);
    close_writes();
    add_item(REQ_FINISH, 1'b1);
    add_item(REQ_START, 1'b1);
    drain();

    // Deep fill past the limit, then empty again and beyond zero
    configure(16'd64, 16'd48, 16'hFFFF, 16'd3);
    repeat (140) add_item(REQ_START, 1'($urandom_range(0, 1)));
    add_random(30, 50);
    drain();
    repeat (150) add_item(REQ_FINISH, 1'($urandom_range(0, 1)));
    drain();

    // Random phases, first two at the register extremes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(16'd0, 16'd0, 16'd0, 16'd0);
        1: configure(16'd1024, 16'd1024, 16'd1024, 16'hFFFF);
        default: configure(pick_limit(), pick_limit(), pick_limit(), pick_rate());
      endcase
      for (int ch = 0; ch < 5; ch++) begin
        add_random(14, $urandom_range(35, 70));
        // hold the sender back until everything in flight has returned
        if (ch == 0 || $urandom_range(0, 3) == 0) drain();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("%0d items in, %0d results checked, %0d register writes over %0d settings",
             items_sent, results_checked, reg_writes, phases_run);
    $display("peak active count %0d, %0d results under high load", peak_busy, overload_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", error_count,
               expected_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
